### rtl/homography_topk_reprojection_core_assert.svh
// Assertion macros for the homography reprojection top-k core.
`ifndef HOMOGRAPHY_TOPK_REPROJECTION_CORE_ASSERT_SVH
`define HOMOGRAPHY_TOPK_REPROJECTION_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define HRT_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("%m: check failed");
`define HRT_ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("%m: reset check failed");
`else
`define HRT_ASSERT(label, prop)
`define HRT_ASSERT_RST(label, prop)
`endif
`endif

### rtl/hrt_pkg.sv
// Shared constants, types and helper functions for the reprojection top-k core.
package hrt_pkg;

    localparam int K_MAX      = 16;
    localparam int KW         = $clog2(K_MAX + 1);
    localparam int KIW        = $clog2(K_MAX);
    localparam int MAX_POINTS = 65536;
    localparam int ACW        = $clog2(MAX_POINTS + 1);
    localparam int IDXW       = 16;
    localparam int ERRW       = 40;
    localparam int CW         = 32;
    localparam int PW         = 16;
    localparam int PRODW      = CW + PW;
    localparam int TW         = 50;
    localparam int QW         = TW + 4;
    localparam int NW         = QW - 1;
    localparam int DW         = TW;
    localparam int DCW        = $clog2(NW + 1);
    localparam int DIFW       = QW + 1;
    localparam int SQW        = 20;
    localparam int QD         = 4;
    localparam int QAW        = $clog2(QD);
    localparam int CFGW       = 64;
    localparam int SELW       = 5;

    localparam logic [ERRW-1:0] ERR_MAX = {ERRW{1'b1}};

    typedef enum logic [2:0] {
        REG_C00_01  = 3'd0,
        REG_C02_10  = 3'd1,
        REG_C11_12  = 3'd2,
        REG_C20_21  = 3'd3,
        REG_C22     = 3'd4,
        REG_SAMPLES = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [CW-1:0] h00;
        logic signed [CW-1:0] h01;
        logic signed [CW-1:0] h02;
        logic signed [CW-1:0] h10;
        logic signed [CW-1:0] h11;
        logic signed [CW-1:0] h12;
        logic signed [CW-1:0] h20;
        logic signed [CW-1:0] h21;
        logic signed [CW-1:0] h22;
    } coeff_t;

    typedef struct packed {
        logic [ERRW-1:0] err;
        logic [IDXW-1:0] idx;
        logic            rank;
        logic            fin;
    } job_t;

    typedef enum logic [2:0] {
        F_IDLE, F_MUL, F_CHK, F_DIV, F_SQ, F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE, B_SCAN, B_REPL, B_SORT, B_MED_A, B_MED_B, B_EMIT
    } back_state_t;

    function automatic logic key_gt(input logic [ERRW-1:0] ea, input logic [IDXW-1:0] ia,
                                    input logic [ERRW-1:0] eb, input logic [IDXW-1:0] ib);
        return (ea > eb) || ((ea == eb) && (ia > ib));
    endfunction

    function automatic logic [KW-1:0] active_k(input logic [SELW-1:0] v);
        logic [KW-1:0] k;
        if (v == '0) begin
            k = KW'(1);
        end else if (int'(v) > K_MAX) begin
            k = KW'(K_MAX);
        end else begin
            k = KW'(v);
        end
        return k;
    endfunction

endpackage

### rtl/homography_topk_reprojection_core.sv
// Homography reprojection error with top-k selection: top level.
// Input beats on s_* carry one correspondence each (src_x, src_y, dst_x, dst_y
// in Q12.4); s_tlast marks the last correspondence of a set. Correspondences
// are numbered from zero in arrival order within the set.
// Each beat is projected through the homography held in the configuration
// registers. The user must write them over cfg_wr_* while the core is idle;
// the core does not enforce this. The front end handles one correspondence at
// a time, including the two 53-step bit-serial divisions of the projection;
// s_tready is high only while it waits for a beat. A four-entry queue
// decouples it from the back end. The back end ranks each error directly,
// or by a scan for the worst kept entry when the kept list is full.
// After the final beat the back end sorts the kept list, computes the median
// and then streams k result beats on m_*, largest error first,
// with m_tlast on the last one. A stalled receiver holds the current beat in
// the output register and halts the back end; the front end keeps working
// until the queue fills.
// Reset clears all control state and loads the identity homography with k = 16.
`include "homography_topk_reprojection_core_assert.svh"
module homography_topk_reprojection_core
    import hrt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // src_x, src_y, dst_x, dst_y
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // point_index, sq_error, median_error
    output logic        m_tuser,   // slot_valid
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_index,
    input  logic [63:0] cfg_wr_data
);

    logic [CFGW-1:0]     c0_reg, c1_reg, c2_reg, c3_reg;
    logic [CW-1:0]       c4_reg;
    logic [SELW-1:0]     samples_reg;
    coeff_t              coeff;
    job_t                q_in, q_out;
    logic                q_push, q_pop, q_full, q_empty;
    logic [KW-1:0]       k;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c0_reg      <= CFGW'(1 << 20);
            c1_reg      <= '0;
            c2_reg      <= CFGW'(1 << 20);
            c3_reg      <= '0;
            c4_reg      <= CW'(1 << 20);
            samples_reg <= SELW'(16);
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_wr_index))
                REG_C00_01:  c0_reg      <= cfg_wr_data;
                REG_C02_10:  c1_reg      <= cfg_wr_data;
                REG_C11_12:  c2_reg      <= cfg_wr_data;
                REG_C20_21:  c3_reg      <= cfg_wr_data;
                REG_C22:     c4_reg      <= cfg_wr_data[CW-1:0];
                REG_SAMPLES: samples_reg <= cfg_wr_data[SELW-1:0];
                default: ;
            endcase
        end
    end

    assign coeff = '{h00: c0_reg[31:0], h01: c0_reg[63:32],
                     h02: c1_reg[31:0], h10: c1_reg[63:32],
                     h11: c2_reg[31:0], h12: c2_reg[63:32],
                     h20: c3_reg[31:0], h21: c3_reg[63:32],
                     h22: c4_reg};
    assign k = active_k(samples_reg);

    hrt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .coeff    (coeff),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .job      (q_in),
        .job_push (q_push),
        .q_full   (q_full)
    );

    hrt_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_in),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_out),
        .empty   (q_empty)
    );

    hrt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .k        (k),
        .head     (q_out),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    `HRT_ASSERT(a_no_push_full, !(q_push && q_full))
    `HRT_ASSERT(a_no_pop_empty, !(q_pop && q_empty))
    `HRT_ASSERT(a_pop_frees_room, (q_full && q_pop && !q_push) |=> !q_full)
    `HRT_ASSERT_RST(a_reset_quiet, !aresetn |=> !m_tvalid)

endmodule

### rtl/hrt_div.sv
// Bit-serial restoring divider giving a truncated signed quotient.
module hrt_div
    import hrt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [QW-1:0] num,
    input  logic signed [TW-1:0] den,
    output logic                 done,
    output logic signed [QW-1:0] quo
);

    logic [NW-1:0]  acc_reg, acc_next;
    logic [DW-1:0]  rem_reg, rem_next;
    logic [DW-1:0]  den_reg;
    logic           neg_reg;
    logic [DCW-1:0] cnt_reg;
    logic           run_reg;
    logic           done_reg;
    logic [QW-1:0]  num_abs;
    logic [TW-1:0]  den_abs;
    logic [DW:0]    rem_sh;
    logic           qbit;

    assign num_abs = num[QW-1] ? QW'(-num) : QW'(num);
    assign den_abs = den[TW-1] ? TW'(-den) : TW'(den);
    assign rem_sh  = {rem_reg, acc_reg[NW-1]};
    assign qbit    = rem_sh >= {1'b0, den_reg};

    always_comb begin
        rem_next = qbit ? DW'(rem_sh - {1'b0, den_reg}) : rem_sh[DW-1:0];
        acc_next = {acc_reg[NW-2:0], qbit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= DCW'(NW);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DCW'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= num_abs[NW-1:0];
            rem_reg <= '0;
            den_reg <= DW'(den_abs);
            neg_reg <= num[QW-1] ^ den[TW-1];
        end else if (run_reg) begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quo  = neg_reg ? QW'(-{1'b0, acc_reg}) : QW'({1'b0, acc_reg});

endmodule

### rtl/hrt_front.sv
// Front end: accepts correspondences, projects them and computes the squared error.
module hrt_front
    import hrt_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  coeff_t         coeff,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [63:0]    s_tdata,
    input  logic           s_tlast,
    output job_t           job,
    output logic           job_push,
    input  logic           q_full
);

    front_state_t state_reg, state_next;

    logic signed [PW-1:0]    sx_reg, sy_reg, dx_reg, dy_reg;
    logic                    fin_reg, rank_reg;
    logic [IDXW-1:0]         idx_reg;
    logic [ACW-1:0]          cnt_reg;
    logic [2:0]              step_reg;
    logic signed [PRODW-1:0] prod_reg;
    logic signed [TW-1:0]    t1_reg, t2_reg, t3_reg;
    logic                    pass_reg;
    logic signed [QW-1:0]    q0_reg, q1_reg;
    logic [SQW-1:0]          dabs_reg;
    logic                    ovf_reg;
    logic [2*SQW:0]          sq_reg;
    logic [ERRW-1:0]         err_reg;

    logic signed [CW-1:0]    mul_a;
    logic signed [PW-1:0]    mul_b;
    logic signed [PRODW-1:0] prod;
    logic signed [TW-1:0]    prod_ext;
    logic                    div_start, div_done;
    logic signed [QW-1:0]    div_num, div_quo;
    logic signed [DIFW-1:0]  diff, dabs;
    logic                    big;
    logic [2*SQW-1:0]        sq_prod;
    logic [2*SQW:0]          sq_sum;
    logic                    rank_in;

    assign rank_in = cnt_reg < ACW'(MAX_POINTS);

    always_comb begin
        case (step_reg)
            3'd0:    begin mul_a = coeff.h00; mul_b = sx_reg; end
            3'd1:    begin mul_a = coeff.h01; mul_b = sy_reg; end
            3'd2:    begin mul_a = coeff.h10; mul_b = sx_reg; end
            3'd3:    begin mul_a = coeff.h11; mul_b = sy_reg; end
            3'd4:    begin mul_a = coeff.h20; mul_b = sx_reg; end
            3'd5:    begin mul_a = coeff.h21; mul_b = sy_reg; end
            default: begin mul_a = '0;        mul_b = '0;     end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign prod_ext = {{(TW-PRODW){prod_reg[PRODW-1]}}, prod_reg};
    assign div_num  = (state_reg == F_DIV) ? {t2_reg, 4'b0} : {t1_reg, 4'b0};

    hrt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (t3_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_comb begin
        if (step_reg == 3'd0) begin
            diff = {{(DIFW-PW){dx_reg[PW-1]}}, dx_reg} - {q0_reg[QW-1], q0_reg};
        end else begin
            diff = {{(DIFW-PW){dy_reg[PW-1]}}, dy_reg} - {q1_reg[QW-1], q1_reg};
        end
        dabs = diff[DIFW-1] ? -diff : diff;
    end

    assign big     = |dabs[DIFW-1:SQW];
    assign sq_prod = dabs_reg * dabs_reg;
    assign sq_sum  = sq_reg + {1'b0, sq_prod};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (s_tvalid) state_next = rank_in ? F_MUL : F_PUSH;
            F_MUL:  if (step_reg == 3'd6) state_next = F_CHK;
            F_CHK:  state_next = (t3_reg == '0) ? F_PUSH : F_DIV;
            F_DIV:  if (div_done && pass_reg) state_next = F_SQ;
            F_SQ:   if (step_reg == 3'd2) state_next = F_PUSH;
            F_PUSH: if (!q_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        job_push  = 1'b0;
        unique case (state_reg)
            F_IDLE: s_tready = 1'b1;
            F_CHK:  div_start = (t3_reg != '0);
            F_DIV:  div_start = div_done && !pass_reg;
            F_PUSH: job_push = !q_full;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == F_IDLE && s_tvalid) begin
                if (s_tlast) begin
                    cnt_reg <= '0;
                end else if (rank_in) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            F_IDLE: begin
                sx_reg   <= s_tdata[15:0];
                sy_reg   <= s_tdata[31:16];
                dx_reg   <= s_tdata[47:32];
                dy_reg   <= s_tdata[63:48];
                fin_reg  <= s_tlast;
                rank_reg <= rank_in;
                idx_reg  <= cnt_reg[IDXW-1:0];
                step_reg <= '0;
                t1_reg   <= {{(TW-CW-4){coeff.h02[CW-1]}}, coeff.h02, 4'b0};
                t2_reg   <= {{(TW-CW-4){coeff.h12[CW-1]}}, coeff.h12, 4'b0};
                t3_reg   <= {{(TW-CW-4){coeff.h22[CW-1]}}, coeff.h22, 4'b0};
            end
            F_MUL: begin
                prod_reg <= prod;
                step_reg <= step_reg + 1'b1;
                case (step_reg)
                    3'd1, 3'd2: t1_reg <= t1_reg + prod_ext;
                    3'd3, 3'd4: t2_reg <= t2_reg + prod_ext;
                    3'd5, 3'd6: t3_reg <= t3_reg + prod_ext;
                    default: ;
                endcase
            end
            F_CHK: begin
                pass_reg <= 1'b0;
                err_reg  <= ERR_MAX;
            end
            F_DIV: begin
                step_reg <= '0;
                if (div_done) begin
                    if (pass_reg) begin
                        q1_reg <= div_quo;
                    end else begin
                        q0_reg   <= div_quo;
                        pass_reg <= 1'b1;
                    end
                end
            end
            F_SQ: begin
                step_reg <= step_reg + 1'b1;
                case (step_reg)
                    3'd0: begin
                        dabs_reg <= dabs[SQW-1:0];
                        ovf_reg  <= big;
                    end
                    3'd1: begin
                        sq_reg   <= {1'b0, sq_prod};
                        dabs_reg <= dabs[SQW-1:0];
                        ovf_reg  <= ovf_reg | big;
                    end
                    default: begin
                        err_reg <= (ovf_reg || sq_sum[2*SQW]) ? ERR_MAX : sq_sum[ERRW-1:0];
                    end
                endcase
            end
            default: ;
        endcase
    end

    assign job = '{err: err_reg, idx: idx_reg, rank: rank_reg, fin: fin_reg};

endmodule

### rtl/hrt_fifo.sv
// Short queue of scored correspondences between the front and back ends.
module hrt_fifo
    import hrt_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t din,
    output logic full,
    input  logic pop,
    output job_t dout,
    output logic empty
);

    job_t           mem [QD];
    logic [QAW-1:0] wr_reg, rd_reg;
    logic [QAW:0]   cnt_reg;

    assign full  = cnt_reg == (QAW+1)'(QD);
    assign empty = cnt_reg == '0;
    assign dout  = mem[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem[wr_reg] <= din;
    end

endmodule

### rtl/hrt_back.sv
// Back end: keeps the lowest errors, sorts them and streams out the report.
module hrt_back
    import hrt_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [KW-1:0] k,
    input  job_t          head,
    input  logic          q_empty,
    output logic          q_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [95:0]   m_tdata,
    output logic          m_tuser,
    output logic          m_tlast
);

    back_state_t state_reg, state_next;

    logic [ERRW-1:0] err_mem [K_MAX];
    logic [IDXW-1:0] idx_mem [K_MAX];
    logic [KW-1:0]   count_reg, scan_reg, round_reg, emit_reg;
    logic [ERRW-1:0] worst_err_reg, med_a_reg, med_reg;
    logic [IDXW-1:0] worst_idx_reg;
    logic [KIW-1:0]  worst_pos_reg;
    job_t            cur_reg;
    logic            m_valid_reg, slot_reg, last_reg;
    logic [ERRW-1:0] out_err_reg, out_med_reg;
    logic [IDXW-1:0] out_idx_reg;

    logic [KW-1:0]   c;
    logic [KIW-1:0]  rd_addr;
    logic [ERRW-1:0] rd_err;
    logic [IDXW-1:0] rd_idx;
    logic [K_MAX-2:0] sw;
    logic            out_load;
    logic [ERRW:0]   med_sum;

    assign c      = (count_reg < k) ? count_reg : k;
    assign rd_err = err_mem[rd_addr];
    assign rd_idx = idx_mem[rd_addr];
    assign med_sum = {1'b0, med_a_reg} + {1'b0, rd_err};

    always_comb begin
        unique case (state_reg)
            B_SCAN:  rd_addr = scan_reg[KIW-1:0];
            B_MED_A: rd_addr = c[KW-1:1];
            B_MED_B: rd_addr = KIW'(c[KW-1:1] - 1'b1);
            B_EMIT:  rd_addr = KIW'(c - emit_reg - 1'b1);
            default: rd_addr = '0;
        endcase
    end

    always_comb begin
        for (int j = 0; j < K_MAX - 1; j++) begin
            sw[j] = (1'(j) == round_reg[0]) && (KW'(j + 1) < count_reg)
                    && key_gt(err_mem[j], idx_mem[j], err_mem[j+1], idx_mem[j+1]);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    if (head.rank && count_reg >= k) begin
                        state_next = B_SCAN;
                    end else if (head.fin) begin
                        state_next = B_SORT;
                    end
                end
            end
            B_SCAN:  if (scan_reg == count_reg - 1'b1) state_next = B_REPL;
            B_REPL:  state_next = cur_reg.fin ? B_SORT : B_IDLE;
            B_SORT:  if (round_reg == KW'(K_MAX - 1)) state_next = B_MED_A;
            B_MED_A: state_next = B_MED_B;
            B_MED_B: state_next = B_EMIT;
            B_EMIT:  if (out_load && emit_reg == k - 1'b1) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_comb begin
        q_pop    = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            B_IDLE:  q_pop = !q_empty;
            B_EMIT:  out_load = !m_valid_reg || m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_IDLE && !q_empty && head.rank && count_reg < k) begin
                count_reg <= count_reg + 1'b1;
            end
            if (out_load && emit_reg == k - 1'b1) begin
                count_reg <= '0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                cur_reg   <= head;
                scan_reg  <= '0;
                round_reg <= '0;
                if (!q_empty && head.rank && count_reg < k) begin
                    err_mem[count_reg[KIW-1:0]] <= head.err;
                    idx_mem[count_reg[KIW-1:0]] <= head.idx;
                end
            end
            B_SCAN: begin
                scan_reg <= scan_reg + 1'b1;
                if (scan_reg == '0
                    || key_gt(rd_err, rd_idx, worst_err_reg, worst_idx_reg)) begin
                    worst_err_reg <= rd_err;
                    worst_idx_reg <= rd_idx;
                    worst_pos_reg <= scan_reg[KIW-1:0];
                end
            end
            B_REPL: begin
                if (worst_err_reg > cur_reg.err) begin
                    err_mem[worst_pos_reg] <= cur_reg.err;
                    idx_mem[worst_pos_reg] <= cur_reg.idx;
                end
            end
            B_SORT: begin
                round_reg <= round_reg + 1'b1;
                for (int j = 0; j < K_MAX - 1; j++) begin
                    if (sw[j]) begin
                        err_mem[j]   <= err_mem[j+1];
                        err_mem[j+1] <= err_mem[j];
                        idx_mem[j]   <= idx_mem[j+1];
                        idx_mem[j+1] <= idx_mem[j];
                    end
                end
            end
            B_MED_A: med_a_reg <= rd_err;
            B_MED_B: begin
                emit_reg <= '0;
                if (c == '0) begin
                    med_reg <= '0;
                end else if (c[0]) begin
                    med_reg <= med_a_reg;
                end else begin
                    med_reg <= med_sum[ERRW:1];
                end
            end
            B_EMIT: begin
                if (out_load) begin
                    emit_reg    <= emit_reg + 1'b1;
                    slot_reg    <= emit_reg < c;
                    out_err_reg <= (emit_reg < c) ? rd_err : '0;
                    out_idx_reg <= (emit_reg < c) ? rd_idx : '0;
                    out_med_reg <= med_reg;
                    last_reg    <= emit_reg == k - 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_med_reg, out_err_reg, out_idx_reg};
    assign m_tuser  = slot_reg;
    assign m_tlast  = last_reg;

endmodule
